[rtl/bdq_pkg.sv]
// Package for the bounded double-ended queue: request and status codes,
// and the control and status structs passed between the top level and the cells.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

    // Request kinds carried on the slave-side tuser.
    typedef enum logic [2:0] {
        ACT_PUSH_BACK  = 3'd0,
        ACT_PUSH_FRONT = 3'd1,
        ACT_POP_BACK   = 3'd2,
        ACT_POP_FRONT  = 3'd3,
        ACT_PEEK       = 3'd4
    } action_t;

    // Result status carried on the master-side tuser.
    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_EMPTY = 2'd2
    } status_t;

    // Per-cycle command broadcast to every cell of the row.
    typedef struct packed {
        logic shift_fwd;   // every cell takes its front-side neighbour (push front)
        logic shift_bwd;   // every cell takes its back-side neighbour (pop front)
        logic put_tail;    // first free cell takes the pushed word (push back)
        logic drop_tail;   // last occupied cell empties (pop back)
    } cell_ctrl_t;

    // What each cell reports about itself.
    typedef struct packed {
        logic occ;         // cell holds a live element
        logic rear;        // cell holds the rear element
    } cell_stat_t;

    localparam int CAP_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(10);

endpackage

`default_nettype wire

[rtl/bounded_deque_top.sv]
// Top level of the bounded double-ended queue: request decode, the row of
// cells, rear selection and the result register. Depends on bdq_pkg, bdq_cell.
//
//  Channel   Direction  Handshake                 Contents
//  s_        in         s_tvalid / s_tready       tdata: push_value; tuser: action
//  m_        out        m_tvalid / m_tready       tdata: popped, front, rear, occupancy;
//                                                 tuser: status
//  cfg_      in         cfg_valid / cfg_ready     capacity_limit
//
// For each word, the row of cells updates as the word is accepted, and the S_LOAD
// state then loads the result register from the cells.
// A new word is taken as soon as the result is loaded, even while it waits on m_tready.
// After reset the queue is empty and the capacity limit is 10.
// A stalled result holds the block in its load step until the result register frees.

`timescale 1ns / 1ps
`default_nettype none

module bounded_deque_top
    import bdq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // Request words.
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [((DATA_WIDTH+7)/8)*8-1:0] s_tdata,  // [DW-1:0] push_value
    input  wire logic [2:0]          s_tuser,              // [2:0] action
    // Result words.
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // From bit 0: popped_value, front_value, rear_value, occupancy, zero fill.
    output logic [((3*DATA_WIDTH+$clog2(DEPTH+1)+7)/8)*8-1:0] m_tdata,
    output logic [1:0]               m_tuser,              // [1:0] status
    // Capacity limit writes.
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [CAP_W-1:0]    cfg_data
);

    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int OUT_BITS = 3 * DATA_WIDTH + CNT_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
    localparam int CMP_W    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_LOAD = 2'b10
    } state_t;

    state_t                state_reg, state_next;
    logic [CAP_W-1:0]      cap_reg;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [DATA_WIDTH-1:0] popped_reg, popped_next;
    status_t               status_reg, status_next;

    logic [DATA_WIDTH-1:0] out_popped_reg, out_front_reg, out_rear_reg;
    logic [CNT_W-1:0]      out_count_reg;
    status_t               out_status_reg;
    logic                  m_tvalid_reg;

    logic                  s_fire;
    logic                  out_load;
    logic                  is_full;
    logic                  is_empty;
    action_t               act;
    logic [DATA_WIDTH-1:0] push_value;
    cell_ctrl_t            ctrl;

    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    cell_stat_t            cell_stat [DEPTH];
    logic [DEPTH-1:0]      occ_vec;
    logic [DATA_WIDTH-1:0] rear_word;
    logic [DATA_WIDTH-1:0] front_word;

    assign s_tready   = (state_reg == S_IDLE);
    assign s_fire     = s_tvalid && s_tready;
    assign cfg_ready  = 1'b1;
    assign act        = action_t'(s_tuser);
    assign push_value = s_tdata[DATA_WIDTH-1:0];

    // Full when the count reaches the written limit or the row itself.
    assign is_full  = (CMP_W'(count_reg) >= CMP_W'(cap_reg)) ||
                      (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);

    // Rear word: AND-OR over the one cell that flags itself as rear.
    always_comb begin
        rear_word = '0;
        for (int i = 0; i < DEPTH; i++) begin
            rear_word = rear_word | (cell_data[i] & {DATA_WIDTH{cell_stat[i].rear}});
        end
    end

    assign front_word = cell_data[0] & {DATA_WIDTH{cell_stat[0].occ}};

    // Request decode: cell command, count update and immediate result parts.
    always_comb begin
        ctrl        = '0;
        count_next  = count_reg;
        popped_next = popped_reg;
        status_next = status_reg;
        if (s_fire) begin
            popped_next = '0;
            status_next = STS_OK;
            case (act)
                ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
                    if (is_full) begin
                        status_next = STS_FULL;
                    end else begin
                        ctrl.put_tail  = (act == ACT_PUSH_BACK);
                        ctrl.shift_fwd = (act == ACT_PUSH_FRONT);
                        count_next     = count_reg + CNT_W'(1);
                    end
                end
                ACT_POP_BACK, ACT_POP_FRONT: begin
                    if (is_empty) begin
                        status_next = STS_EMPTY;
                    end else begin
                        popped_next    = (act == ACT_POP_BACK) ? rear_word : front_word;
                        ctrl.drop_tail = (act == ACT_POP_BACK);
                        ctrl.shift_bwd = (act == ACT_POP_FRONT);
                        count_next     = count_reg - CNT_W'(1);
                    end
                end
                default: begin
                    // Peek and unused codes leave the queue as it is.
                end
            endcase
        end
    end

    // The row of cells; the ends see the pushed word and an empty neighbour.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] l_data, r_data;
        logic                  l_occ, r_occ;

        if (g == 0) begin : g_first
            assign l_data = push_value;
            assign l_occ  = 1'b1;
        end else begin : g_mid_l
            assign l_data = cell_data[g-1];
            assign l_occ  = cell_stat[g-1].occ;
        end

        if (g == DEPTH - 1) begin : g_last
            assign r_data = '0;
            assign r_occ  = 1'b0;
        end else begin : g_mid_r
            assign r_data = cell_data[g+1];
            assign r_occ  = cell_stat[g+1].occ;
        end

        bdq_cell #(
            .DATA_WIDTH(DATA_WIDTH)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .push_data (push_value),
            .left_data (l_data),
            .left_occ  (l_occ),
            .right_data(r_data),
            .right_occ (r_occ),
            .data_out  (cell_data[g]),
            .stat      (cell_stat[g])
        );

        assign occ_vec[g] = cell_stat[g].occ;
    end

    // Sequencing: accept, then load the result register once it is free.
    assign out_load = (state_reg == S_LOAD) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            cap_reg      <= CAP_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_valid && cfg_ready) begin
                cap_reg <= cfg_data;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        popped_reg <= popped_next;
        status_reg <= status_next;
        if (out_load) begin
            out_popped_reg <= popped_reg;
            out_status_reg <= status_reg;
            out_front_reg  <= front_word;
            out_rear_reg   <= rear_word;
            out_count_reg  <= count_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = OUT_W'({out_count_reg, out_rear_reg, out_front_reg, out_popped_reg});

    // The count never passes the number of cells.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("element count beyond row length");

    // The occupied cells always number exactly the count.
    a_count_match: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(occ_vec) == 32'(count_reg))
        else $error("occupied cells disagree with count");

    // Live elements sit packed from the front cell onwards.
    a_packed: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot({1'b0, occ_vec} + {{DEPTH{1'b0}}, 1'b1}))
        else $error("gap in occupied cells");

    // A refused push leaves the count as it was.
    a_refused: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && (act == ACT_PUSH_BACK || act == ACT_PUSH_FRONT) && is_full)
        |=> (count_reg == $past(count_reg)))
        else $error("refused push changed the count");

endmodule

`default_nettype wire

[rtl/bdq_cell.sv]
// One cell of the queue row: a data word and an occupied flag, loaded from
// either neighbour or from the pushed word. Depends on bdq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bdq_cell
    import bdq_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire cell_ctrl_t            ctrl,
    input  wire logic [DATA_WIDTH-1:0] push_data,
    input  wire logic [DATA_WIDTH-1:0] left_data,
    input  wire logic                  left_occ,
    input  wire logic [DATA_WIDTH-1:0] right_data,
    input  wire logic                  right_occ,
    output logic      [DATA_WIDTH-1:0] data_out,
    output cell_stat_t                 stat
);

    logic [DATA_WIDTH-1:0] data_reg, data_next;
    logic                  occ_reg, occ_next;
    logic                  is_free_slot;
    logic                  is_rear;

    // A cell knows its own role from its own flag and its neighbours' flags alone.
    assign is_free_slot = !occ_reg && left_occ;
    assign is_rear      = occ_reg && !right_occ;

    // Next contents of the cell.
    always_comb begin
        data_next = data_reg;
        occ_next  = occ_reg;
        if (ctrl.shift_fwd) begin
            data_next = left_data;
            occ_next  = left_occ;
        end else if (ctrl.shift_bwd) begin
            data_next = right_data;
            occ_next  = right_occ;
        end else if (ctrl.put_tail && is_free_slot) begin
            data_next = push_data;
            occ_next  = 1'b1;
        end else if (ctrl.drop_tail && is_rear) begin
            occ_next  = 1'b0;
        end
    end

    // Occupied flag is control state and is cleared at reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    // The data word needs no reset; it is only read while occupied.
    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_out  = data_reg;
    assign stat.occ  = occ_reg;
    assign stat.rear = is_rear;

endmodule

`default_nettype wire
